### hw/rtl/fee_pkg.sv
package fee_pkg;

	localparam int DIM_W   = 7;
	localparam int SUM_W   = 20;
	localparam int SQ_W    = 28;
	localparam int N_W     = 14;
	localparam int PROD_W  = 48;
	localparam int ACC_W   = 46;
	localparam int ALU_W   = 64;
	localparam int REM_W   = 40;
	localparam int DV_W    = 62;
	localparam int QUO_W   = 19;
	localparam int ROOT_W  = 18;
	localparam int RESP_W  = 10;
	localparam int EDGE_W  = 8;
	localparam int CNT_W   = 5;
	localparam int DIV_SHIFT = QUO_W - 1;
	localparam int CFG_IDX_W = 1;

	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_SHIFT);
	localparam logic [CNT_W-1:0] SQ_LAST  = CNT_W'(8);

	localparam logic [DIM_W-1:0] BOX_RESET = DIM_W'(4);

	localparam logic [RESP_W-1:0] RESP_MAX = 10'h1FF;
	localparam logic [RESP_W-1:0] RESP_MIN = 10'h200;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BOX_ACROSS = 1'b0,
		REG_BOX_ALONG  = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_MAX  = 2'd1,
		KIND_MIN  = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MN,
		S_MQ1,
		S_MS1,
		S_MQ2,
		S_MS2,
		S_MD,
		S_MNN,
		S_FLR,
		S_DVL,
		S_DIV,
		S_SQL,
		S_SQ,
		S_FIN
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MN,
		OP_MQ1,
		OP_MS1,
		OP_MQ2,
		OP_MS2,
		OP_MD,
		OP_MNN,
		OP_FLR,
		OP_DVL,
		OP_DIV,
		OP_SQL,
		OP_SQ,
		OP_FIN
	} dp_op_t;

	typedef struct packed {
		dp_op_t           op;
		logic [CNT_W-1:0] cnt;
	} dp_ctrl_t;

	typedef struct packed {
		logic              start;
		logic [RESP_W-1:0] resp;
	} resp_beat_t;

endpackage

### hw/rtl/fee_seq.sv
module fee_seq
	import fee_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_tvalid,
	output logic     in_tready,
	input  logic     fin_ready,
	output dp_ctrl_t ctrl
);

	state_t           state_q;
	state_t           state_nxt;
	logic [CNT_W-1:0] cnt_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: if (in_tvalid) state_nxt = S_MN;
			S_MN:   state_nxt = S_MQ1;
			S_MQ1:  state_nxt = S_MS1;
			S_MS1:  state_nxt = S_MQ2;
			S_MQ2:  state_nxt = S_MS2;
			S_MS2:  state_nxt = S_MD;
			S_MD:   state_nxt = S_MNN;
			S_MNN:  state_nxt = S_FLR;
			S_FLR:  state_nxt = S_DVL;
			S_DVL:  state_nxt = S_DIV;
			S_DIV:  if (cnt_q == '0) state_nxt = S_SQL;
			S_SQL:  state_nxt = S_SQ;
			S_SQ:   if (cnt_q == '0) state_nxt = S_FIN;
			S_FIN:  if (fin_ready) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		in_tready = 1'b0;
		ctrl.cnt  = cnt_q;
		ctrl.op   = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				in_tready = 1'b1;
				if (in_tvalid) ctrl.op = OP_LOAD;
			end
			S_MN:  ctrl.op = OP_MN;
			S_MQ1: ctrl.op = OP_MQ1;
			S_MS1: ctrl.op = OP_MS1;
			S_MQ2: ctrl.op = OP_MQ2;
			S_MS2: ctrl.op = OP_MS2;
			S_MD:  ctrl.op = OP_MD;
			S_MNN: ctrl.op = OP_MNN;
			S_FLR: ctrl.op = OP_FLR;
			S_DVL: ctrl.op = OP_DVL;
			S_DIV: ctrl.op = OP_DIV;
			S_SQL: ctrl.op = OP_SQL;
			S_SQ:  ctrl.op = OP_SQ;
			S_FIN: if (fin_ready) ctrl.op = OP_FIN;
			default: ctrl.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			unique case (state_q)
				S_DVL:   cnt_q <= DIV_LAST;
				S_SQL:   cnt_q <= SQ_LAST;
				S_DIV,
				S_SQ:    cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_div_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (cnt_q <= DIV_LAST))
		else $error("divide step count out of range");
`endif

endmodule

### hw/rtl/fee_datapath.sv
module fee_datapath
	import fee_pkg::*;
(
	input  logic             clk,
	input  dp_ctrl_t         ctrl,
	input  logic [DIM_W-1:0] box_across,
	input  logic [DIM_W-1:0] box_along,
	input  logic             line_start,
	input  logic [SUM_W-1:0] sum_first,
	input  logic [SUM_W-1:0] sum_second,
	input  logic [SQ_W-1:0]  sumsq_first,
	input  logic [SQ_W-1:0]  sumsq_second,
	output resp_beat_t       beat
);

	logic [SUM_W-1:0]  s1_q, s2_q, d_q;
	logic [SQ_W-1:0]   q1_q, q2_q;
	logic              start_q, neg_q;
	logic [N_W-1:0]    n_q;
	logic [PROD_W-1:0] p_q;
	logic [ACC_W-1:0]  acc_q;
	logic [REM_W-1:0]  rem_q;
	logic [DV_W-1:0]   dv_q;
	logic [QUO_W-1:0]  quo_q;
	logic [ROOT_W-1:0] root_q;

	logic [DIM_W-1:0]  w_eff, l_eff;
	logic [SUM_W-1:0]  mul_a;
	logic [SQ_W-1:0]   mul_b;
	logic [PROD_W-1:0] mul_y;
	logic [ALU_W-1:0]  alu_a, alu_b, alu_y;
	logic              alu_sub, alu_neg;
	logic [ROOT_W-1:0] bit_mask, trial;
	logic              in_neg;
	logic [RESP_W-2:0] k_mag;
	logic [RESP_W-1:0] resp;

	assign w_eff = (box_across == '0) ? DIM_W'(1) : box_across;
	assign l_eff = (box_along == '0) ? DIM_W'(1) : box_along;
	assign in_neg = sum_second < sum_first;

	// shared multiplier, operands picked per step
	always_comb begin
		unique case (ctrl.op)
			OP_MN: begin
				mul_a = SUM_W'(w_eff);
				mul_b = SQ_W'(l_eff);
			end
			OP_MQ1: begin
				mul_a = SUM_W'(p_q[N_W-1:0]);
				mul_b = q1_q;
			end
			OP_MS1: begin
				mul_a = s1_q;
				mul_b = SQ_W'(s1_q);
			end
			OP_MQ2: begin
				mul_a = SUM_W'(n_q);
				mul_b = q2_q;
			end
			OP_MS2: begin
				mul_a = s2_q;
				mul_b = SQ_W'(s2_q);
			end
			OP_MD: begin
				mul_a = d_q;
				mul_b = SQ_W'(d_q);
			end
			default: begin
				mul_a = SUM_W'(n_q);
				mul_b = SQ_W'(n_q);
			end
		endcase
	end

	assign mul_y = {{(PROD_W-SUM_W){1'b0}}, mul_a} * {{(PROD_W-SQ_W){1'b0}}, mul_b};

	assign bit_mask = ROOT_W'(1) << {ctrl.cnt, 1'b0};
	assign trial    = root_q + bit_mask;

	// shared add / subtract unit
	always_comb begin
		alu_sub = 1'b1;
		unique case (ctrl.op)
			OP_DIV: begin
				alu_a = {{(ALU_W-REM_W){1'b0}}, rem_q};
				alu_b = {{(ALU_W-DV_W){1'b0}}, dv_q};
			end
			OP_SQ: begin
				alu_a = {{(ALU_W-REM_W){1'b0}}, rem_q};
				alu_b = {{(ALU_W-ROOT_W){1'b0}}, trial};
			end
			default: begin
				alu_a = {{(ALU_W-ACC_W){acc_q[ACC_W-1]}}, acc_q};
				alu_b = {{(ALU_W-PROD_W){1'b0}}, p_q};
				alu_sub = (ctrl.op != OP_MS2);
			end
		endcase
	end

	assign alu_y   = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
	assign alu_neg = alu_y[ALU_W-1];

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_LOAD: begin
				s1_q    <= sum_first;
				s2_q    <= sum_second;
				q1_q    <= sumsq_first;
				q2_q    <= sumsq_second;
				start_q <= line_start;
				neg_q   <= in_neg;
				d_q     <= in_neg ? sum_first - sum_second : sum_second - sum_first;
			end
			OP_MN: p_q <= mul_y;
			OP_MQ1: begin
				n_q <= p_q[N_W-1:0];
				p_q <= mul_y;
			end
			OP_MS1: begin
				acc_q <= p_q[ACC_W-1:0];
				p_q   <= mul_y;
			end
			OP_MQ2, OP_MS2, OP_MD: begin
				acc_q <= alu_y[ACC_W-1:0];
				p_q   <= mul_y;
			end
			OP_MNN: begin
				rem_q <= p_q[REM_W-1:0];
				p_q   <= mul_y;
			end
			// variance floor of one
			OP_FLR: if (alu_neg) acc_q <= p_q[ACC_W-1:0];
			OP_DVL: begin
				dv_q  <= {acc_q[DV_W-DIV_SHIFT-1:0], {DIV_SHIFT{1'b0}}};
				quo_q <= '0;
			end
			OP_DIV: begin
				if (!alu_neg) rem_q <= alu_y[REM_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], !alu_neg};
				dv_q  <= dv_q >> 1;
			end
			OP_SQL: begin
				rem_q  <= REM_W'(quo_q[QUO_W-2:0]);
				root_q <= '0;
			end
			OP_SQ: begin
				if (!alu_neg) begin
					rem_q  <= alu_y[REM_W-1:0];
					root_q <= (root_q >> 1) + bit_mask;
				end else begin
					root_q <= root_q >> 1;
				end
			end
			default: begin
			end
		endcase
	end

	assign k_mag = root_q[RESP_W-2:0];

	always_comb begin
		if (neg_q) begin
			resp = quo_q[QUO_W-1] ? RESP_MIN : ~{1'b0, k_mag} + RESP_W'(1);
		end else begin
			resp = quo_q[QUO_W-1] ? RESP_MAX : {1'b0, k_mag};
		end
	end

	assign beat.start = start_q;
	assign beat.resp  = resp;

endmodule

### hw/rtl/fee_extrema.sv
module fee_extrema
	import fee_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fin_go,
	input  resp_beat_t        beat,
	output logic              fin_ready,
	output logic              out_tvalid,
	input  logic              out_tready,
	output logic [EDGE_W-1:0] edge_value,
	output kind_t             extremum_kind
);

	logic signed [RESP_W-1:0] last_q;
	logic                     rise_q, fall_q;
	logic                     valid_q;
	logic [EDGE_W-1:0]        edge_q;
	kind_t                    kind_q;

	logic signed [RESP_W-1:0] cur;
	logic                     rise_nxt, fall_nxt;
	logic [EDGE_W-1:0]        edge_nxt;
	kind_t                    kind_nxt;
	logic [EDGE_W-1:0]        prev_sat;

	assign cur = $signed(beat.resp);

	always_comb begin
		if (last_q > $signed(RESP_W'(127))) begin
			prev_sat = 8'h7F;
		end else if (last_q < $signed(RESP_W'(-128))) begin
			prev_sat = 8'h80;
		end else begin
			prev_sat = last_q[EDGE_W-1:0];
		end
	end

	always_comb begin
		rise_nxt = rise_q;
		fall_nxt = fall_q;
		edge_nxt = '0;
		kind_nxt = KIND_NONE;
		if (cur < last_q) begin
			if (rise_q) begin
				edge_nxt = prev_sat;
				kind_nxt = KIND_MAX;
				rise_nxt = 1'b0;
			end
			fall_nxt = 1'b1;
		end else if (cur > last_q) begin
			if (fall_q) begin
				edge_nxt = prev_sat;
				kind_nxt = KIND_MIN;
				fall_nxt = 1'b0;
			end
			rise_nxt = 1'b1;
		end
	end

	assign fin_ready = !valid_q || out_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			rise_q  <= 1'b0;
			fall_q  <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (fin_go) begin
				last_q  <= cur;
				rise_q  <= beat.start ? 1'b0 : rise_nxt;
				fall_q  <= beat.start ? 1'b0 : fall_nxt;
				valid_q <= !beat.start;
			end else if (out_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			edge_q <= edge_nxt;
			kind_q <= kind_nxt;
		end
	end

	assign out_tvalid    = valid_q;
	assign edge_value    = edge_q;
	assign extremum_kind = kind_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |-> (!valid_q || out_tready))
		else $error("result register overwritten while stalled");
	a_dir_flags: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({rise_q, fall_q}))
		else $error("rising and falling flags both set");
`endif

endmodule

### hw/rtl/fisher_edge_extrema_detector.sv
// a new input beat is taken only after the previous one finishes, and finishing waits while the output stalls;
// the steps share one multiplier and one add/subtract unit
//   (7 multiply steps, floor and two setup steps, 19 divide steps, 9 square root steps,
//   load and finish)
// s_axis_tready is high only while the sequencer is idle
// asynchronous active-low reset: box width and length to 4, last response and flags to zero
module fisher_edge_extrema_detector
	import fee_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// sum_first, sum_second, sumsq_first, sumsq_second
	input  logic [95:0]          s_axis_tdata,
	// line_start
	input  logic                 s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// edge_value
	output logic [7:0]           m_axis_tdata,
	// extremum_kind
	output logic [1:0]           m_axis_tuser
);

	logic [DIM_W-1:0] box_across_q, box_along_q;
	dp_ctrl_t         ctrl;
	resp_beat_t       beat;
	logic             fin_ready;
	kind_t            kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_across_q <= BOX_RESET;
			box_along_q  <= BOX_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BOX_ACROSS: box_across_q <= cfg_data;
				REG_BOX_ALONG:  box_along_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	fee_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_tvalid (s_axis_tvalid),
		.in_tready (s_axis_tready),
		.fin_ready (fin_ready),
		.ctrl      (ctrl)
	);

	fee_datapath u_datapath (
		.clk          (clk),
		.ctrl         (ctrl),
		.box_across   (box_across_q),
		.box_along    (box_along_q),
		.line_start   (s_axis_tuser),
		.sum_first    (s_axis_tdata[19:0]),
		.sum_second   (s_axis_tdata[39:20]),
		.sumsq_first  (s_axis_tdata[67:40]),
		.sumsq_second (s_axis_tdata[95:68]),
		.beat         (beat)
	);

	fee_extrema u_extrema (
		.clk           (clk),
		.arst_n        (arst_n),
		.fin_go        (ctrl.op == OP_FIN),
		.beat          (beat),
		.fin_ready     (fin_ready),
		.out_tvalid    (m_axis_tvalid),
		.out_tready    (m_axis_tready),
		.edge_value    (m_axis_tdata),
		.extremum_kind (kind)
	);

	assign m_axis_tuser = kind;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted again while busy");
`endif

endmodule
